// ===== hdl/htid_pkg.sv =====
// Shared types, widths and constants for the Hilbert tile id converter.
// Used by the channel interfaces, the step unit and the top level.
`timescale 1ns / 1ps

package htid_pkg;

   // Field widths
   localparam int DEEPEST_ZOOM = 31;
   localparam int ZOOM_W       = 5;
   localparam int COORD_W      = 31;
   localparam int TILE_W       = 63;
   localparam int DIGIT_W      = 2 * DEEPEST_ZOOM;
   localparam int BIT_W        = $clog2(ZOOM_W);

   // Request actions
   localparam logic ACT_FORWARD = 1'b0;
   localparam logic ACT_REVERSE = 1'b1;

   // First tile number past the deepest zoom: sum of 4^i for i up to DEEPEST_ZOOM
   localparam logic [TILE_W-1:0] BASE_LIMIT = {1'b1, {DEEPEST_ZOOM{2'b01}}};

   // Control for one Hilbert level step
   typedef struct packed {
      logic              reverse;
      logic [ZOOM_W-1:0] lvl;
      logic [1:0]        digit;
   } step_ctrl_type;

   // First tile number of a zoom level: sum of 4^i for i below z
   function automatic logic [TILE_W-1:0] level_base(input logic [ZOOM_W-1:0] z);
      logic [TILE_W-1:0] keep;
      keep = ~({TILE_W{1'b1}} << {z, 1'b0});
      return BASE_LIMIT & keep;
   endfunction

   // Mask of the coordinate bits below bit position z
   function automatic logic [COORD_W-1:0] low_mask(input logic [ZOOM_W-1:0] z);
      return ~({COORD_W{1'b1}} << z);
   endfunction

endpackage

// ===== hdl/htid_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on htid_pkg for the field widths.
`timescale 1ns / 1ps

interface htid_req_if import htid_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                action;
   logic [ZOOM_W-1:0]   zoom;
   logic [COORD_W-1:0]  x_coord;
   logic [COORD_W-1:0]  y_coord;
   logic [TILE_W-1:0]   tile_number;

   modport source (output valid, action, zoom, x_coord, y_coord, tile_number,
                   input ready);
   modport sink   (input valid, action, zoom, x_coord, y_coord, tile_number,
                   output ready);
endinterface

interface htid_rsp_if import htid_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TILE_W-1:0]   out_tile_number;
   logic [ZOOM_W-1:0]   out_zoom;
   logic [COORD_W-1:0]  out_x;
   logic [COORD_W-1:0]  out_y;
   logic                range_error;

   modport source (output valid, out_tile_number, out_zoom, out_x, out_y, range_error,
                   input ready);
   modport sink   (input valid, out_tile_number, out_zoom, out_x, out_y, range_error,
                   output ready);
endinterface

// ===== hdl/htid_step_unit.sv =====
// One Hilbert curve level step, shared by the forward and reverse conversions.
// Depends on htid_pkg for widths and the step control struct.
`timescale 1ns / 1ps

module htid_step_unit import htid_pkg::*; (
   input  step_ctrl_type      ctrl,
   input  logic [COORD_W-1:0] x_cur,
   input  logic [COORD_W-1:0] y_cur,
   output logic [COORD_W-1:0] x_nxt,
   output logic [COORD_W-1:0] y_nxt,
   output logic [1:0]         quad
);

   logic [COORD_W-1:0] mask;
   logic [COORD_W-1:0] tx;
   logic [COORD_W-1:0] ty;
   logic [COORD_W-1:0] sx;
   logic [COORD_W-1:0] sy;
   logic [COORD_W-1:0] sbit;
   logic               rx;
   logic               ry;

   always_comb begin
      mask = low_mask(ctrl.lvl);
      sbit = COORD_W'(1) << ctrl.lvl;

      // pick the quadrant bits from the digit or from the coordinates
      if (ctrl.reverse) begin
         rx = ctrl.digit[1];
         ry = ctrl.digit[0] ^ ctrl.digit[1];
      end else begin
         rx = x_cur[ctrl.lvl];
         ry = y_cur[ctrl.lvl];
      end
      quad = {rx, rx ^ ry};

      // flip the sub-square in the lower right quadrant, transpose it in both lower quadrants
      tx = x_cur;
      ty = y_cur;
      if (!ry && rx) begin
         tx = mask & ~x_cur;
         ty = mask & ~y_cur;
      end
      if (!ry) begin
         sx = ty;
         sy = tx;
      end else begin
         sx = tx;
         sy = ty;
      end

      // place the quadrant offset when rebuilding coordinates
      if (ctrl.reverse) begin
         x_nxt = sx | (rx ? sbit : '0);
         y_nxt = sy | (ry ? sbit : '0);
      end else begin
         x_nxt = sx;
         y_nxt = sy;
      end
   end

endmodule

// ===== hdl/hilbert_tile_id_convert_top.sv =====
// Top level of the Hilbert tile id converter: sequencer, registers, output stage.
// Depends on htid_pkg, htid_if and htid_step_unit.
`timescale 1ns / 1ps

// Usage
//   req_ch carries one request: action 0 turns zoom, x_coord and y_coord into a
//   tile number; action 1 turns tile_number into zoom, column and row.
//   rsp_ch returns exactly one response per request, with range_error set and
//   all other fields zero when a coordinate lies at or beyond 2^zoom or the
//   tile number lies past the deepest zoom level.
//   One request is worked at a time; req_ch.ready is high only while idle.
//   Work from the accepting edge to rsp_ch.valid:
//     forward: one level step per Hilbert level, none at zoom zero;
//     reverse: a binary zoom search, a base subtract,
//              then one level step per zoom level;
//     range errors: straight to the response, with no level steps.
//   Levels run one per cycle through the single shared step unit; that unit
//   and the zoom search set the latency.
//   The response is held in registers while rsp_ch.ready is low; no new
//   request is taken until it is delivered.
//   Synchronous reset returns the sequencer to idle and drops any response.

module hilbert_tile_id_convert_top import htid_pkg::*; (
   input logic        clock,
   input logic        reset,
   htid_req_if.sink   req_ch,
   htid_rsp_if.source rsp_ch
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FWD    = 6'b000010,
      ST_SEARCH = 6'b000100,
      ST_SUB    = 6'b001000,
      ST_REV    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [ZOOM_W-1:0]  lvl_ff, lvl_in;
   logic [ZOOM_W-1:0]  zoom_ff, zoom_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic [DIGIT_W-1:0] d_ff, d_in;
   logic [TILE_W-1:0]  tn_ff, tn_in;
   logic [TILE_W-1:0]  out_tile_ff, out_tile_in;
   logic [ZOOM_W-1:0]  out_zoom_ff, out_zoom_in;
   logic [COORD_W-1:0] out_x_ff, out_x_in;
   logic [COORD_W-1:0] out_y_ff, out_y_in;
   logic               out_err_ff, out_err_in;

   step_ctrl_type      step_ctrl;
   logic [COORD_W-1:0] step_x;
   logic [COORD_W-1:0] step_y;
   logic [1:0]         step_quad;
   logic [ZOOM_W-1:0]  cand;
   logic [TILE_W-1:0]  diff;
   logic               coord_bad;

   htid_step_unit u_step (
      .ctrl  (step_ctrl),
      .x_cur (x_ff),
      .y_cur (y_ff),
      .x_nxt (step_x),
      .y_nxt (step_y),
      .quad  (step_quad)
   );

   assign req_ch.ready           = (state_ff == ST_IDLE);
   assign rsp_ch.valid           = (state_ff == ST_DONE);
   assign rsp_ch.out_tile_number = out_tile_ff;
   assign rsp_ch.out_zoom        = out_zoom_ff;
   assign rsp_ch.out_x           = out_x_ff;
   assign rsp_ch.out_y           = out_y_ff;
   assign rsp_ch.range_error     = out_err_ff;

   // check coordinates against the grid and form search and subtract terms
   always_comb begin
      coord_bad = |((req_ch.x_coord | req_ch.y_coord) & ~low_mask(req_ch.zoom));
      cand      = zoom_ff | (ZOOM_W'(1) << bit_ff);
      diff      = tn_ff - level_base(zoom_ff);
   end

   // sequence one request through the shared step unit
   always_comb begin
      state_in    = state_ff;
      lvl_in      = lvl_ff;
      zoom_in     = zoom_ff;
      bit_in      = bit_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      d_in        = d_ff;
      tn_in       = tn_ff;
      out_tile_in = out_tile_ff;
      out_zoom_in = out_zoom_ff;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_err_in  = out_err_ff;

      step_ctrl.reverse = (state_ff == ST_REV);
      step_ctrl.lvl     = lvl_ff;
      step_ctrl.digit   = d_ff[1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               out_tile_in = '0;
               out_zoom_in = '0;
               out_x_in    = '0;
               out_y_in    = '0;
               out_err_in  = 1'b0;
               if (req_ch.action == ACT_FORWARD) begin
                  x_in    = req_ch.x_coord;
                  y_in    = req_ch.y_coord;
                  zoom_in = req_ch.zoom;
                  lvl_in  = req_ch.zoom - ZOOM_W'(1);
                  d_in    = '0;
                  if (coord_bad) begin
                     out_err_in = 1'b1;
                     state_in   = ST_DONE;
                  end else if (req_ch.zoom == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_FWD;
                  end
               end else begin
                  tn_in   = req_ch.tile_number;
                  zoom_in = '0;
                  bit_in  = BIT_W'(ZOOM_W - 1);
                  if (req_ch.tile_number >= BASE_LIMIT) begin
                     out_err_in = 1'b1;
                     state_in   = ST_DONE;
                  end else begin
                     state_in = ST_SEARCH;
                  end
               end
            end
         end

         ST_FWD: begin
            // shift in one quadrant digit, most significant level first
            d_in   = {d_ff[DIGIT_W-3:0], step_quad};
            x_in   = step_x;
            y_in   = step_y;
            lvl_in = lvl_ff - ZOOM_W'(1);
            if (lvl_ff == '0) begin
               out_tile_in = level_base(zoom_ff) + {1'b0, d_in};
               state_in    = ST_DONE;
            end
         end

         ST_SEARCH: begin
            // binary search for the deepest level whose base is not above the number
            if (level_base(cand) <= tn_ff) begin
               zoom_in = cand;
            end
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               state_in = ST_SUB;
            end
         end

         ST_SUB: begin
            d_in   = diff[DIGIT_W-1:0];
            x_in   = '0;
            y_in   = '0;
            lvl_in = '0;
            if (zoom_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_REV;
            end
         end

         ST_REV: begin
            // consume one digit, least significant level first
            d_in   = d_ff >> 2;
            x_in   = step_x;
            y_in   = step_y;
            lvl_in = lvl_ff + ZOOM_W'(1);
            if (lvl_ff == zoom_ff - ZOOM_W'(1)) begin
               out_zoom_in = zoom_ff;
               out_x_in    = step_x;
               out_y_in    = step_y;
               state_in    = ST_DONE;
            end
         end

         ST_DONE: begin
            // hold the response until taken
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working and response registers
   always_ff @(posedge clock) begin
      lvl_ff      <= lvl_in;
      zoom_ff     <= zoom_in;
      bit_ff      <= bit_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      d_ff        <= d_in;
      tn_ff       <= tn_in;
      out_tile_ff <= out_tile_in;
      out_zoom_ff <= out_zoom_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_err_ff  <= out_err_in;
   end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Hilbert tile id converter, forward and reverse.
// Depends on htid_pkg, htid_if and hilbert_tile_id_convert_top; predicts every response itself.
`timescale 1ns / 1ps

module tb;
   import htid_pkg::*;

   typedef struct packed {
      logic               action;
      logic [ZOOM_W-1:0]  zoom;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [TILE_W-1:0]  tile_number;
   } tile_request_type;

   typedef struct packed {
      logic [TILE_W-1:0]  tile_number;
      logic [ZOOM_W-1:0]  zoom;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               range_error;
   } tile_answer_type;

   localparam int QUIET_LIMIT = 4000;
   localparam int END_CYCLES  = 50;

   logic clock;
   logic reset;

   htid_req_if req_ch ();
   htid_rsp_if rsp_ch ();

   hilbert_tile_id_convert_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   tile_answer_type answers_due[$];
   int              mismatch_count = 0;
   int              quiet_cycles   = 0;
   int              hold_left      = 0;
   bit              steady_mode    = 1'b0;

   // Clock generator
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // First tile number of zoom z: sum of 4^i for i below z
   function automatic logic [63:0] zoom_first_tile(input int z);
      logic [63:0] acc;
      logic [63:0] p4;
      acc = 64'd0;
      p4  = 64'd1;
      for (int i = 0; i < z; i++) begin
         acc = acc + p4;
         p4  = p4 << 2;
      end
      return acc;
   endfunction

   // Distance of (x,y) along the Hilbert curve on a 2^z grid, top level first
   function automatic logic [63:0] hilbert_distance(input int z, input logic [63:0] x_in,
                                                    input logic [63:0] y_in);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] s;
      logic [63:0] d;
      logic [63:0] tmp;
      logic        rx;
      logic        ry;
      logic [1:0]  quad;
      x = x_in;
      y = y_in;
      d = 64'd0;
      for (int lvl = z - 1; lvl >= 0; lvl--) begin
         s    = 64'd1 << lvl;
         rx   = (x & s) != 64'd0;
         ry   = (y & s) != 64'd0;
         quad = {rx, rx ^ ry};
         d    = d + (s * s) * {62'd0, quad};
         if (!ry) begin
            if (rx) begin
               x = (s - 64'd1) ^ (x & (s - 64'd1));
               y = (s - 64'd1) ^ (y & (s - 64'd1));
            end
            tmp = x;
            x   = y;
            y   = tmp;
         end
      end
      return d;
   endfunction

   // Point at distance d on a 2^z Hilbert curve, bottom level first
   function automatic void hilbert_point(input int z, input logic [63:0] d,
                                         output logic [63:0] px, output logic [63:0] py);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] tmp;
      logic        rx;
      logic        ry;
      x = 64'd0;
      y = 64'd0;
      t = d;
      for (int lvl = 0; lvl < z; lvl++) begin
         s  = 64'd1 << lvl;
         rx = t[1];
         ry = t[0] ^ rx;
         if (!ry) begin
            if (rx) begin
               x = (s - 64'd1) ^ (x & (s - 64'd1));
               y = (s - 64'd1) ^ (y & (s - 64'd1));
            end
            tmp = x;
            x   = y;
            y   = tmp;
         end
         if (rx) x = x + s;
         if (ry) y = y + s;
         t = t >> 2;
      end
      px = x;
      py = y;
   endfunction

   // Full response for one request
   function automatic tile_answer_type predict_answer(input tile_request_type r);
      tile_answer_type a;
      logic [63:0]     lim;
      logic [63:0]     sum;
      logic [63:0]     tn;
      logic [63:0]     acc;
      logic [63:0]     p4;
      logic [63:0]     cx;
      logic [63:0]     cy;
      int              zz;
      a = '0;
      if (r.action == ACT_FORWARD) begin
         lim = 64'd1 << r.zoom;
         if ({33'd0, r.x} >= lim || {33'd0, r.y} >= lim) begin
            a.range_error = 1'b1;
         end else begin
            sum = zoom_first_tile(int'(r.zoom))
                + hilbert_distance(int'(r.zoom), {33'd0, r.x}, {33'd0, r.y});
            a.tile_number = sum[TILE_W-1:0];
         end
      end else begin
         tn = {1'b0, r.tile_number};
         if (tn >= zoom_first_tile(DEEPEST_ZOOM + 1)) begin
            a.range_error = 1'b1;
         end else begin
            acc = 64'd0;
            p4  = 64'd1;
            zz  = 0;
            // find the zoom whose range holds the number
            while (zz < DEEPEST_ZOOM && tn >= acc + p4) begin
               acc = acc + p4;
               p4  = p4 << 2;
               zz++;
            end
            hilbert_point(zz, tn - acc, cx, cy);
            a.zoom = zz[ZOOM_W-1:0];
            a.x    = cx[COORD_W-1:0];
            a.y    = cy[COORD_W-1:0];
         end
      end
      return a;
   endfunction

   // ---------------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------------

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Idle length: mostly none or short, a few long
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COORD_W-1:0] coord_below(input int z);
      logic [63:0] m;
      m = (64'd1 << z) - 64'd1;
      return COORD_W'($urandom & m[31:0]);
   endfunction

   function automatic tile_request_type random_request();
      tile_request_type r;
      int               pick;
      int               z;
      logic [63:0]      off;
      logic [63:0]      tn;
      pick          = $urandom_range(0, 99);
      r.action      = ACT_FORWARD;
      r.zoom        = ZOOM_W'($urandom);
      r.x           = COORD_W'($urandom);
      r.y           = COORD_W'($urandom);
      r.tile_number = TILE_W'(rand64());
      if (pick < 40) begin
         // forward, coordinates on the grid
         z      = $urandom_range(0, DEEPEST_ZOOM);
         r.zoom = ZOOM_W'(z);
         r.x    = coord_below(z);
         r.y    = coord_below(z);
      end else if (pick < 52) begin
         // forward, one coordinate pushed off the grid
         z      = $urandom_range(0, DEEPEST_ZOOM - 1);
         r.zoom = ZOOM_W'(z);
         r.x    = coord_below(z);
         r.y    = coord_below(z);
         if ($urandom_range(0, 1)) r.x = r.x | (COORD_W'(1) << z) | COORD_W'($urandom << z);
         else                      r.y = r.y | (COORD_W'(1) << z) | COORD_W'($urandom << z);
      end else if (pick < 88) begin
         // reverse, number inside a chosen zoom range
         z             = $urandom_range(0, DEEPEST_ZOOM);
         off           = rand64() & ((64'd1 << (2 * z)) - 64'd1);
         tn            = zoom_first_tile(z) + off;
         r.action      = ACT_REVERSE;
         r.tile_number = tn[TILE_W-1:0];
      end else if (pick < 94) begin
         // reverse, near a zoom boundary
         z             = $urandom_range(1, DEEPEST_ZOOM + 1);
         tn            = zoom_first_tile(z) - 64'd1 + 64'($urandom_range(0, 1));
         r.action      = ACT_REVERSE;
         r.tile_number = tn[TILE_W-1:0];
      end else begin
         // reverse, any 63-bit number
         r.action = ACT_REVERSE;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------------

   // Present one request after a random gap unless in steady mode, record its answer when taken
   task automatic send_request(input tile_request_type r);
      int gap;
      gap = steady_mode ? 0 : idle_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= r.action;
      req_ch.zoom        <= r.zoom;
      req_ch.x_coord     <= r.x;
      req_ch.y_coord     <= r.y;
      req_ch.tile_number <= r.tile_number;
      @(posedge clock);
      while (!(req_ch.valid && req_ch.ready)) @(posedge clock);
      answers_due.push_back(predict_answer(r));
   endtask

   task automatic send_forward(input int z, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y);
      tile_request_type r;
      r.action      = ACT_FORWARD;
      r.zoom        = ZOOM_W'(z);
      r.x           = x;
      r.y           = y;
      r.tile_number = TILE_W'(rand64());
      send_request(r);
   endtask

   task automatic send_reverse(input logic [63:0] tn);
      tile_request_type r;
      r.action      = ACT_REVERSE;
      r.zoom        = ZOOM_W'($urandom);
      r.x           = COORD_W'($urandom);
      r.y           = COORD_W'($urandom);
      r.tile_number = tn[TILE_W-1:0];
      send_request(r);
   endtask

   // Drop valid and hold until every outstanding response is back
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (answers_due.size() != 0);
   endtask

   // ---------------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 40)
         $display("ERROR at %0t: %s got 0x%0h, predicted 0x%0h", $time, field, got, want);
      mismatch_count++;
   endtask

   task automatic check_answer();
      tile_answer_type want;
      if (answers_due.size() == 0) begin
         report_mismatch("response with no request outstanding", 64'd0, 64'd0);
         return;
      end
      want = answers_due.pop_front();
      if (rsp_ch.out_tile_number !== want.tile_number)
         report_mismatch("out_tile_number", 64'(rsp_ch.out_tile_number), 64'(want.tile_number));
      if (rsp_ch.out_zoom !== want.zoom)
         report_mismatch("out_zoom", 64'(rsp_ch.out_zoom), 64'(want.zoom));
      if (rsp_ch.out_x !== want.x)
         report_mismatch("out_x", 64'(rsp_ch.out_x), 64'(want.x));
      if (rsp_ch.out_y !== want.y)
         report_mismatch("out_y", 64'(rsp_ch.out_y), 64'(want.y));
      if (rsp_ch.range_error !== want.range_error)
         report_mismatch("range_error", 64'(rsp_ch.range_error), 64'(want.range_error));
   endtask

   // Check taken responses, then stall the receiver at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_answer();
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!steady_mode && $urandom_range(0, 3) == 0) hold_left <= idle_len();
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("hilbert_tile_id_convert_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Grid corners, zoom zero, deepest zoom and coordinates just off the grid
   task automatic test_forward_corners();
      send_forward(0, 0, 0);
      send_forward(0, 1, 0);
      send_forward(0, 0, 1);
      send_forward(1, 0, 0);
      send_forward(1, 0, 1);
      send_forward(1, 1, 1);
      send_forward(1, 1, 0);
      send_forward(5, 31, 31);
      send_forward(5, 32, 0);
      send_forward(30, 0, 31'h4000_0000);
      send_forward(31, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_forward(31, 31'h7FFF_FFFF, 0);
      send_forward(31, 0, 0);
   endtask

   // Zoom range boundaries, the last valid number and numbers past it
   task automatic test_reverse_corners();
      send_reverse(64'd0);
      send_reverse(64'd1);
      send_reverse(64'd4);
      send_reverse(64'd5);
      send_reverse(zoom_first_tile(DEEPEST_ZOOM) - 64'd1);
      send_reverse(zoom_first_tile(DEEPEST_ZOOM));
      send_reverse({1'b0, BASE_LIMIT} - 64'd1);
      send_reverse({1'b0, BASE_LIMIT});
      send_reverse(64'h7FFF_FFFF_FFFF_FFFF);
      send_reverse(zoom_first_tile(16) + 64'd3);
      drain_responses();
   endtask

   // Back-to-back traffic with no idling on either side
   task automatic test_random_steady(input int count);
      steady_mode = 1'b1;
      repeat (count) send_request(random_request());
      steady_mode = 1'b0;
   endtask

   // Random gaps on both sides, with an occasional full drain
   task automatic test_random_bursty(input int count);
      for (int i = 0; i < count; i++) begin
         send_request(random_request());
         if (i % 100 == 99) drain_responses();
      end
   endtask

   // Main sequence
   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.action      <= ACT_FORWARD;
      req_ch.zoom        <= '0;
      req_ch.x_coord     <= '0;
      req_ch.y_coord     <= '0;
      req_ch.tile_number <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_forward_corners();
      test_reverse_corners();
      test_random_steady(150);
      test_random_bursty(700);

      // Wait out the last responses, then a margin
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (answers_due.size() != 0);
      repeat (END_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("hilbert_tile_id_convert_top: match");
      end else begin
         $display("hilbert_tile_id_convert_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/htid_pkg.sv
hdl/htid_if.sv
hdl/htid_step_unit.sv
hdl/hilbert_tile_id_convert_top.sv
tb/tb.sv
